// ===== hw/rtl/b64e_pkg.sv =====
// shared types, constants and the alphabet lookup for the base64 stream encoder
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned SLOT_COUNT = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
        logic       message_done;
    } out_item_t;

    // one character to emit: either a sextet or padding
    typedef struct packed {
        logic       pad;
        logic [5:0] sextet;
    } slot_t;

    // everything the back end needs to emit the run of one input byte
    typedef struct packed {
        logic [1:0]               last_idx;
        logic                     eom;
        slot_t [SLOT_COUNT-1:0]   slot;
    } cmd_t;

    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2,
        PHASE_X = 2'd3
    } phase_t;

    function automatic logic [7:0] b64e_char(input logic [5:0] s);
        logic [7:0] v;
        v = {2'b00, s};
        if (s < 6'd26)
            return 8'h41 + v;
        else if (s < 6'd52)
            return 8'h61 + v - 8'd26;
        else if (s < 6'd62)
            return 8'h30 + v - 8'd52;
        else if (s == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64e_front.sv =====
// front end: accepts bytes, tracks group phase and splits each byte into a character run
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire in_item_t byte_item,
    output logic          push,
    output cmd_t          push_cmd,
    input  wire logic     queue_full
);

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] b;
    logic       eom;

    assign byte_stall = queue_full;
    assign push       = byte_valid && !queue_full;
    assign b          = byte_item.data_byte;
    assign eom        = byte_item.end_of_message;

    always_comb
    begin
        push_cmd     = '0;
        push_cmd.eom = eom;
        phase_next   = phase_reg;
        left_next    = left_reg;
        unique case (phase_reg)
            PHASE_1:
            begin
                push_cmd.slot[0].sextet = {left_reg[1:0], b[7:4]};
                push_cmd.last_idx       = 2'd0;
                if (eom)
                begin
                    push_cmd.slot[1].sextet = {b[3:0], 2'b00};
                    push_cmd.slot[2].pad    = 1'b1;
                    push_cmd.last_idx       = 2'd2;
                end
                phase_next = PHASE_2;
                left_next  = b[3:0];
            end
            PHASE_2:
            begin
                push_cmd.slot[0].sextet = {left_reg, b[7:6]};
                push_cmd.slot[1].sextet = b[5:0];
                push_cmd.last_idx       = 2'd1;
                phase_next = PHASE_0;
                left_next  = '0;
            end
            PHASE_0, PHASE_X:
            begin
                push_cmd.slot[0].sextet = b[7:2];
                push_cmd.last_idx       = 2'd0;
                if (eom)
                begin
                    push_cmd.slot[1].sextet = {b[1:0], 4'b0000};
                    push_cmd.slot[2].pad    = 1'b1;
                    push_cmd.slot[3].pad    = 1'b1;
                    push_cmd.last_idx       = 2'd3;
                end
                phase_next = PHASE_1;
                left_next  = {2'b00, b[1:0]};
            end
            default:
            begin
                phase_next = PHASE_0;
                left_next  = '0;
            end
        endcase
        // end of message starts the next message clean
        if (eom)
        begin
            phase_next = PHASE_0;
            left_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_0;
            left_reg  <= '0;
        end
        else if (push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_queue.sv =====
// two-entry command queue between the front end and the back end
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue
    import b64e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head_cmd,
    input  wire logic pop
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (!push && pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_back.sv =====
// back end: walks the head command into the output register one character per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire cmd_t head_cmd,
    output logic      pop,
    output logic      char_valid,
    input  wire logic char_stall,
    output out_item_t char_item
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    logic       load;
    logic       at_last;
    slot_t      cur;

    assign char_valid = out_valid_reg;
    assign char_item  = out_reg;

    // output register frees up when empty or when its transaction completes
    assign load    = head_valid && (!out_valid_reg || !char_stall);
    assign cur     = head_cmd.slot[idx_reg];
    assign at_last = (idx_reg == head_cmd.last_idx);
    assign pop     = load && at_last;

    always_comb
    begin
        out_next              = out_reg;
        out_next.out_char     = cur.pad ? PAD_CHAR : b64e_char(cur.sextet);
        out_next.last_char    = at_last;
        out_next.message_done = at_last && head_cmd.eom;
        idx_next              = at_last ? 2'd0 : idx_reg + 2'd1;
        out_valid_next        = out_valid_reg && char_stall;
        if (load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
                idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_encoder_unit.sv =====
// top level of the streaming base64 encoder
`timescale 1ns / 1ps
`default_nettype none

// Streaming base64 encoder (standard alphabet, '=' padding). Each byte transaction
// carries one raw byte and an end-of-message flag; it yields one character in group
// positions 0 and 1 and two in position 2, and on the last byte of a message also the
// partial sextet and padding, with last_char on the final character of each byte's run
// and message_done on the final character of the message. A byte is taken in any cycle
// the two-entry command queue has room; characters leave at one per cycle from the
// output register while char_stall is low, so the output port sets the pace. The first
// character of a byte passes through the command queue and then the output register
// before it is presented on the output.
module base64_stream_encoder_unit
    import b64e_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_stall,
    input  wire in_item_t byte_item,
    output logic          char_valid,
    input  wire logic     char_stall,
    output out_item_t     char_item
);

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic head_valid;
    cmd_t head_cmd;
    logic pop;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .push       (push),
        .push_cmd   (push_cmd),
        .queue_full (queue_full)
    );

    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/b64e_checker.sv =====
// port-level checks for the base64 encoder and their binding to the top level
`timescale 1ns / 1ps
`default_nettype none

module b64e_checker
    import b64e_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      byte_valid,
    input wire logic      byte_stall,
    input wire logic      char_valid,
    input wire logic      char_stall,
    input wire out_item_t char_item
);

    logic [7:0] c;
    logic       legal;

    assign c     = char_item.out_char;
    assign legal = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h30 && c <= 8'h39) || c == 8'h2B || c == 8'h2F ||
                   c == PAD_CHAR;

    // every character is from the alphabet or padding
    a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> legal)
        else $error("illegal output character");

    // message end is always the last character of a run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_item.message_done) |-> char_item.last_char)
        else $error("message_done without last_char");

    // padding only closes a message
    a_pad_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && c == PAD_CHAR && char_item.last_char) |-> char_item.message_done)
        else $error("padding closes a run that is not the message end");

    // a stalled transaction holds
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_stall) |=> (char_valid && $stable(char_item)))
        else $error("output changed while stalled");

    // an accepted byte has output presented after it passes the queue and the output register
    a_byte_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_stall) |=> ##1 char_valid)
        else $error("accepted byte produced no output");

endmodule

bind base64_stream_encoder_unit b64e_checker u_b64e_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
);

`default_nettype wire

// ===== bench/b64_char_checker.sv =====
// checker that predicts the base64 characters of each byte transaction and compares them
`timescale 1ns / 1ps

module b64_char_checker
    import b64e_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    input  wire logic      byte_stall,
    input  wire in_item_t  byte_item,
    input  wire logic      char_valid,
    input  wire logic      char_stall,
    input  wire out_item_t char_item,
    output int             mismatches,
    output int             chars_owed
);

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int REPORT_LIMIT = 10;

    phase_t     group_pos;
    logic [3:0] carry_bits;
    out_item_t  expected_chars[$];
    int         error_total = 0;

    // first alphabet character sits in the top byte of the literal
    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] s);
        return ALPHABET[8 * (63 - int'(s)) +: 8];
    endfunction

    task automatic predict_chars(input in_item_t item);
        logic [7:0] b;
        logic       eom;
        logic [7:0] run [4];
        int         n;
        int         i;
        logic       last_one;
        b   = item.data_byte;
        eom = item.end_of_message;
        case (group_pos)
            PHASE_1:
            begin
                run[0]     = sextet_to_ascii({carry_bits[1:0], b[7:4]});
                carry_bits = b[3:0];
                group_pos  = PHASE_2;
                n          = 1;
                if (eom)
                begin
                    run[1] = sextet_to_ascii({carry_bits, 2'b00});
                    run[2] = PAD_CHAR;
                    n      = 3;
                end
            end
            PHASE_2:
            begin
                run[0]     = sextet_to_ascii({carry_bits, b[7:6]});
                run[1]     = sextet_to_ascii(b[5:0]);
                carry_bits = 4'd0;
                group_pos  = PHASE_0;
                n          = 2;
            end
            default:
            begin
                run[0]     = sextet_to_ascii(b[7:2]);
                carry_bits = {2'b00, b[1:0]};
                group_pos  = PHASE_1;
                n          = 1;
                if (eom)
                begin
                    run[1] = sextet_to_ascii({carry_bits[1:0], 4'b0000});
                    run[2] = PAD_CHAR;
                    run[3] = PAD_CHAR;
                    n      = 4;
                end
            end
        endcase
        // a finished message starts the next one from a clean group
        if (eom)
        begin
            group_pos  = PHASE_0;
            carry_bits = 4'd0;
        end
        for (i = 0; i < n; i++)
        begin
            last_one = (i == n - 1);
            expected_chars.push_back({run[i], last_one, last_one & eom});
        end
    endtask

    task automatic report(input string what, input out_item_t want, input out_item_t got);
        error_total++;
        if (error_total <= REPORT_LIMIT)
            $display({"%0t checker: %s: expected char %h last %b done %b,",
                      " got char %h last %b done %b"},
                     $time, what, want.out_char, want.last_char, want.message_done,
                     got.out_char, got.last_char, got.message_done);
    endtask

    task automatic check_char(input out_item_t got);
        out_item_t want;
        if (expected_chars.size() == 0)
        begin
            report("character with none pending", '0, got);
            return;
        end
        want = expected_chars.pop_front();
        if (got.out_char !== want.out_char || got.last_char !== want.last_char
            || got.message_done !== want.message_done)
            report("character mismatch", want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos  = PHASE_0;
            carry_bits = 4'd0;
            expected_chars.delete();
        end
        else
        begin
            if (byte_valid && !byte_stall)
                predict_chars(byte_item);
            if (char_valid && !char_stall)
                check_char(char_item);
        end
        chars_owed <= expected_chars.size();
        mismatches <= error_total;
    end

endmodule

// ===== bench/tb_top.sv =====
// top of the base64 encoder bench: clock, reset, byte stimulus, output pacing and verdict
`timescale 1ns / 1ps

module tb_top;
    import b64e_pkg::*;

    localparam int BYTE_TARGET   = 360;
    localparam int CALM_AFTER    = 300;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      char_valid;
    logic      char_stall;
    out_item_t char_item;
    int        mismatches;
    int        chars_owed;
    logic      calm;

    base64_stream_encoder_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    b64_char_checker char_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item),
        .mismatches (mismatches),
        .chars_owed (chars_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // offers one byte and returns at the edge where the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= {b, eom};
        @(posedge clk);
        while (byte_stall) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int         bytes_sent;
        int         msg_len;
        int         i;
        logic [7:0] data;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        calm       <= 1'b0;
        bytes_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // messages ending in each group position, with all-zero and all-one bytes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b1);
        send_byte(8'h4D, 1'b0); send_byte(8'h61, 1'b0); send_byte(8'h6E, 1'b1);
        send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFC, 1'b0); send_byte(8'h03, 1'b0); send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0); send_byte(8'hAA, 1'b1);

        while (bytes_sent < BYTE_TARGET)
        begin
            msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 9);
            for (i = 0; i < msg_len; i++)
            begin
                data = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                                   : 8'($urandom);
                send_byte(data, i == msg_len - 1);
                bytes_sent++;
                calm <= (bytes_sent >= CALM_AFTER);
            end
        end
        byte_valid <= 1'b0;

        @(posedge clk);
        while (chars_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && chars_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // output side holds off in random bursts until the calm tail of the run
    initial
    begin : char_pacing
        int burst;
        char_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 14);
                char_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            char_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && !byte_stall) || (char_valid && !char_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
